// ===== rtl/plip_pkg.sv =====
// Shared types and codes of the prefixed integer literal parser.
package plip_pkg;

	typedef logic [3:0] err_t;

	localparam err_t E_OK    = 4'd0;
	localparam err_t E_EMPTY = 4'd1;
	localparam err_t E_SHORT = 4'd2;
	localparam err_t E_BASE  = 4'd3;
	localparam err_t E_CHAR  = 4'd4;
	localparam err_t E_DIGIT = 4'd5;
	localparam err_t E_MUL   = 4'd6;
	localparam err_t E_ADD   = 4'd7;
	localparam err_t E_MAX   = 4'd8;
	localparam err_t E_MIN   = 4'd9;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_OCT = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	localparam int unsigned ValueW = 64;
	localparam int unsigned OutW   = 72;

	// UINT64_MAX / 10 + 1
	localparam logic [ValueW-1:0] DEC_CUTOFF = 64'h1999_9999_9999_999A;

	typedef struct packed {
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       is_o;
		logic       is_b;
		logic       is_alnum;
		logic [5:0] digit;
	} char_class_t;

	typedef struct packed {
		logic [ValueW-1:0] mag;
		logic              neg;
		logic              sgn;
		err_t              err;
	} fin_t;

endpackage

// ===== rtl/prefixed_integer_literal_parser_top.sv =====
// Top level of the prefixed integer literal parser: stream ports and pipeline.
//
// Parses an integer literal sent one byte per request (optional sign in signed mode,
// optional 0x/0o/0b prefix, letters as digits 10-35) and returns one result,
// value and error code, for each request marked tlast. A byte request is taken
// every cycle; the byte is classified on entry and registered before it is folded
// into the accumulator, and a literal's result leaves after its last request
// through a range-check stage and the output register. Back-pressure
// on the result side stalls input only once a last request is waiting.
module prefixed_integer_literal_parser_top import plip_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,      // signed_mode
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,        // char_code
	input  logic [0:0]      s_tuser,        // no_char
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OutW-1:0] m_tdata         // value [63:0], error_code [67:64], zero pad
);

	logic              sgn_q;
	char_class_t       cls_in;
	logic              v_s1;
	char_class_t       cls_s1;
	logic              nochar_s1;
	logic              last_s1;
	logic              v_s2;
	fin_t              fin;
	fin_t              fin_s2;
	logic              m_valid_q;
	logic [OutW-1:0]   m_data_q;
	logic              out_adv;
	logic              s2_adv;
	logic              s1_go;
	logic [ValueW-1:0] res_value;
	err_t              res_err;

	assign out_adv  = !m_valid_q || m_tready;
	assign s2_adv   = !v_s2 || out_adv;
	assign s1_go    = v_s1 && (!last_s1 || s2_adv);
	assign s_tready = !v_s1 || s1_go;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	plip_decode u_decode (
		.char_code (s_tdata),
		.cls       (cls_in)
	);

	plip_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.sgn_mode (sgn_q),
		.step     (s1_go),
		.byte_en  (s1_go && !nochar_s1),
		.last     (last_s1),
		.cls      (cls_s1),
		.fin      (fin)
	);

	plip_finish u_finish (
		.fin        (fin_s2),
		.value      (res_value),
		.error_code (res_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgn_q <= 1'b1;
		end else if (cfg_we) begin
			sgn_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			cls_s1    <= cls_in;
			nochar_s1 <= s_tuser[0];
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_adv) begin
			v_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			fin_s2 <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			m_data_q <= {{(OutW-ValueW-4){1'b0}}, res_err, res_value};
		end
	end

`ifndef NO_ASSERTIONS
	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] == E_OK || m_tdata[63:0] == '0))
		else $error("result with error carries a nonzero value");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] <= E_MIN))
		else $error("error code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && last_s1 && v_s2 && m_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1 && !s2_adv) |=> (v_s1 && last_s1))
		else $error("stalled last request lost");
`endif

endmodule

// ===== rtl/plip_decode.sv =====
// Character classifier: sign, zero, prefix letters and digit value.
module plip_decode import plip_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	logic [7:0] low;
	logic       is_num;
	logic       is_let;

	always_comb begin
		low    = char_code | 8'h20;
		is_num = (char_code >= 8'h30) && (char_code <= 8'h39);
		is_let = (low >= 8'h61) && (low <= 8'h7A);
		cls.is_plus  = (char_code == 8'h2B);
		cls.is_minus = (char_code == 8'h2D);
		cls.is_zero  = (char_code == 8'h30);
		cls.is_x     = (char_code == 8'h78);
		cls.is_o     = (char_code == 8'h6F);
		cls.is_b     = (char_code == 8'h62);
		cls.is_alnum = is_num | is_let;
		if (is_num) begin
			cls.digit = 6'(char_code - 8'h30);
		end else if (is_let) begin
			cls.digit = 6'(low - 8'h61 + 8'd10);
		end else begin
			cls.digit = '0;
		end
	end

endmodule

// ===== rtl/plip_core.sv =====
// Literal state machine and accumulator: takes one classified byte a cycle while byte_en is set.
module plip_core import plip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sgn_mode,
	input  logic        step,
	input  logic        byte_en,
	input  logic        last,
	input  char_class_t cls,
	output fin_t        fin
);

	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_AFTER_SIGN = 3'd1,
		PH_ZERO       = 3'd2,
		PH_PREFIX_OK  = 3'd3,
		PH_DIGITS     = 3'd4,
		PH_PREFIX_BAD = 3'd5
	} phase_t;

	phase_t            ph_q, ph_n;
	logic              neg_q, neg_n;
	radix_t            rx_q, rx_n;
	logic [ValueW-1:0] acc_q, acc_n;
	err_t              err_q, err_n;

	logic              too_big;
	logic              mul_ovf;
	logic [ValueW-1:0] prod;
	logic [ValueW:0]   sum;
	err_t              dig_err;

	// one digit step: shifts and adds for the multiply
	always_comb begin
		case (rx_q)
			RX_DEC: begin
				too_big = cls.digit >= 6'd10;
				mul_ovf = acc_q >= DEC_CUTOFF;
				prod    = (acc_q << 3) + (acc_q << 1);
			end
			RX_HEX: begin
				too_big = cls.digit >= 6'd16;
				mul_ovf = |acc_q[ValueW-1:ValueW-4];
				prod    = acc_q << 4;
			end
			RX_OCT: begin
				too_big = cls.digit >= 6'd8;
				mul_ovf = |acc_q[ValueW-1:ValueW-3];
				prod    = acc_q << 3;
			end
			default: begin
				too_big = cls.digit >= 6'd2;
				mul_ovf = acc_q[ValueW-1];
				prod    = acc_q << 1;
			end
		endcase
		sum = {1'b0, prod} + {{(ValueW-5){1'b0}}, cls.digit};
		if (!cls.is_alnum) begin
			dig_err = E_CHAR;
		end else if (too_big) begin
			dig_err = E_DIGIT;
		end else if (mul_ovf) begin
			dig_err = E_MUL;
		end else if (sum[ValueW]) begin
			dig_err = E_ADD;
		end else begin
			dig_err = E_OK;
		end
	end

	always_comb begin
		ph_n  = ph_q;
		neg_n = neg_q;
		rx_n  = rx_q;
		acc_n = acc_q;
		err_n = err_q;
		if (byte_en && err_q == E_OK) begin
			case (ph_q)
				PH_START, PH_AFTER_SIGN: begin
					if (ph_q == PH_START && sgn_mode && (cls.is_plus || cls.is_minus)) begin
						neg_n = cls.is_minus;
						ph_n  = PH_AFTER_SIGN;
					end else if (cls.is_zero) begin
						ph_n = PH_ZERO;
					end else begin
						ph_n  = PH_DIGITS;
						err_n = dig_err;
						acc_n = sum[ValueW-1:0];
					end
				end
				PH_ZERO: begin
					if (cls.is_x) begin
						rx_n = RX_HEX;
						ph_n = PH_PREFIX_OK;
					end else if (cls.is_o) begin
						rx_n = RX_OCT;
						ph_n = PH_PREFIX_OK;
					end else if (cls.is_b) begin
						rx_n = RX_BIN;
						ph_n = PH_PREFIX_OK;
					end else begin
						ph_n = PH_PREFIX_BAD;
					end
				end
				PH_PREFIX_BAD: begin
					err_n = E_BASE;
				end
				default: begin
					ph_n  = PH_DIGITS;
					err_n = dig_err;
					acc_n = sum[ValueW-1:0];
				end
			endcase
		end
	end

	// end-of-literal checks that do not need the range test
	always_comb begin
		fin.mag = acc_n;
		fin.neg = neg_n;
		fin.sgn = sgn_mode;
		fin.err = err_n;
		if (err_n == E_OK) begin
			case (ph_n)
				PH_START, PH_AFTER_SIGN:     fin.err = E_EMPTY;
				PH_PREFIX_OK, PH_PREFIX_BAD: fin.err = E_SHORT;
				PH_ZERO:                     fin.mag = '0;
				default:                     fin.err = E_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_START;
			neg_q <= 1'b0;
			rx_q  <= RX_DEC;
			acc_q <= '0;
			err_q <= E_OK;
		end else if (step) begin
			if (last) begin
				ph_q  <= PH_START;
				neg_q <= 1'b0;
				rx_q  <= RX_DEC;
				acc_q <= '0;
				err_q <= E_OK;
			end else begin
				ph_q  <= ph_n;
				neg_q <= neg_n;
				rx_q  <= rx_n;
				acc_q <= acc_n;
				err_q <= err_n;
			end
		end
	end

endmodule

// ===== rtl/plip_finish.sv =====
// int64 range check and two's complement of the finished magnitude, both in signed mode only.
module plip_finish import plip_pkg::*; (
	input  fin_t              fin,
	output logic [ValueW-1:0] value,
	output err_t              error_code
);

	always_comb begin
		error_code = fin.err;
		if (fin.err == E_OK && fin.sgn) begin
			if (!fin.neg && fin.mag[ValueW-1]) begin
				error_code = E_MAX;
			end else if (fin.neg && fin.mag[ValueW-1] && |fin.mag[ValueW-2:0]) begin
				error_code = E_MIN;
			end
		end
		if (error_code != E_OK) begin
			value = '0;
		end else if (fin.sgn && fin.neg) begin
			value = '0 - fin.mag;
		end else begin
			value = fin.mag;
		end
	end

endmodule

// ===== bench/prefixed_integer_literal_parser_top_test.sv =====
// Self-checking bench for the prefixed integer literal parser: directed and random literals.
module prefixed_integer_literal_parser_top_test;
	import plip_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 10;
	localparam int PHASE_ITEMS = 260;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGNED,
		ST_LEAD_ZERO,
		ST_PREFIX,
		ST_DIGITS,
		ST_BAD_PREFIX
	} lit_state_t;

	class parse_scoreboard;
		typedef struct {
			logic [63:0] value;
			err_t        code;
		} parse_t;

		parse_t      expected_parses[$];
		int          mismatches = 0;
		logic        signed_mode = 1'b1;
		lit_state_t  lit_state = ST_IDLE;
		logic        negative = 1'b0;
		radix_t      radix = RX_DEC;
		logic [63:0] acc = '0;
		err_t        first_err = E_OK;

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		function void clear_literal();
			lit_state = ST_IDLE;
			negative  = 1'b0;
			radix     = RX_DEC;
			acc       = '0;
			first_err = E_OK;
		endfunction

		function err_t fold_digit(logic [7:0] c);
			logic [7:0]  low;
			logic [63:0] d, base, cutoff, sum;
			low = c | 8'h20;
			case (radix)
				RX_HEX:  base = 64'd16;
				RX_OCT:  base = 64'd8;
				RX_BIN:  base = 64'd2;
				default: base = 64'd10;
			endcase
			cutoff = 64'hFFFF_FFFF_FFFF_FFFF / base + 64'd1;
			if (c >= "0" && c <= "9")
				d = 64'(c - "0");
			else if (low >= "a" && low <= "z")
				d = 64'(low - "a" + 8'd10);
			else
				return E_CHAR;
			if (d >= base)
				return E_DIGIT;
			if (acc >= cutoff)
				return E_MUL;
			acc = acc * base;
			sum = acc + d;
			if (sum < acc)
				return E_ADD;
			acc = sum;
			return E_OK;
		endfunction

		function void take_byte(logic [7:0] c);
			if (first_err != E_OK)
				return;
			if (lit_state == ST_IDLE && signed_mode && (c == "+" || c == "-")) begin
				negative  = (c == "-");
				lit_state = ST_SIGNED;
			end else if (lit_state == ST_IDLE || lit_state == ST_SIGNED) begin
				if (c == "0") begin
					lit_state = ST_LEAD_ZERO;
				end else begin
					lit_state = ST_DIGITS;
					first_err = fold_digit(c);
				end
			end else begin
				case (lit_state)
					ST_LEAD_ZERO: begin
						lit_state = ST_PREFIX;
						if (c == "x")
							radix = RX_HEX;
						else if (c == "o")
							radix = RX_OCT;
						else if (c == "b")
							radix = RX_BIN;
						else
							lit_state = ST_BAD_PREFIX;
					end
					ST_BAD_PREFIX: first_err = E_BASE;
					default: begin
						lit_state = ST_DIGITS;
						first_err = fold_digit(c);
					end
				endcase
			end
		endfunction

		function void note_request(logic [7:0] c, logic none, logic lst);
			parse_t      r;
			logic [63:0] mag;
			if (!none)
				take_byte(c);
			if (!lst)
				return;
			r.code = first_err;
			mag    = '0;
			if (r.code == E_OK) begin
				case (lit_state)
					ST_IDLE, ST_SIGNED:        r.code = E_EMPTY;
					ST_PREFIX, ST_BAD_PREFIX:  r.code = E_SHORT;
					ST_DIGITS:                 mag = acc;
					default: ;
				endcase
			end
			if (r.code == E_OK && signed_mode) begin
				if (!negative && mag[63])
					r.code = E_MAX;
				else if (negative && mag > 64'h8000_0000_0000_0000)
					r.code = E_MIN;
			end
			r.value = '0;
			if (r.code == E_OK)
				r.value = (signed_mode && negative) ? 64'd0 - mag : mag;
			expected_parses.push_back(r);
			clear_literal();
		endfunction

		task check_result(logic [63:0] value, err_t code);
			parse_t want;
			if (expected_parses.size() == 0) begin
				report($sformatf("unexpected result value=%h code=%0d", value, code));
				return;
			end
			want = expected_parses.pop_front();
			if (value !== want.value)
				report($sformatf("value %h, want %h", value, want.value));
			if (code !== want.code)
				report($sformatf("error code %0d, want %0d", code, want.code));
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic            cfg_wdata = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [7:0]      s_tdata = '0;
	logic [0:0]      s_tuser = '0;
	logic            s_tlast = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	parse_scoreboard sb = new();
	int              idle_cycles = 0;
	int              items_sent = 0;
	int              burst_left = 8;
	bit              hold_off = 1'b0;

	prefixed_integer_literal_parser_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[63:0], m_tdata[67:64]);
		if (!arst_n || (m_tvalid && m_tready) || (s_tvalid && s_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("prefixed_integer_literal_parser_top test failed");
			$finish;
		end
	end

	// result side: changing stall patterns, plus one long hold-off on request
	initial begin
		int pattern;
		int left;
		pattern = 0;
		left    = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				pattern = $urandom_range(0, 3);
				left    = $urandom_range(20, 120);
			end
			left--;
			case (pattern)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= (left[1:0] != 2'd0);
			endcase
		end
	end

	task automatic send_item(input logic [7:0] c, input logic none, input logic lst);
		s_tvalid   <= 1'b1;
		s_tdata    <= c;
		s_tuser    <= none;
		s_tlast    <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(c, none, lst);
		if (!none || lst)
			items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
		end
	endtask

	task automatic send_bytes(input logic [7:0] q[$], input bit nochar_end, input bit noisy);
		int i;
		for (i = 0; i < q.size(); i++) begin
			if (noisy && $urandom_range(0, 24) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			send_item(q[i], 1'b0, !nochar_end && i == q.size() - 1);
		end
		if (nochar_end || q.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic send_text(input string s, input bit nochar_end);
		logic [7:0] q[$];
		int         i;
		for (i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_bytes(q, nochar_end, 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_parses.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		sb.signed_mode = mode;
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase(input logic mode, input bit squeeze);
		int          kind, ndig, digit, first, n, maxlen, i;
		int unsigned base;
		radix_t      radix;
		logic [63:0] v;
		string       s;
		logic [7:0]  q[$];
		set_mode(mode);
		items_sent = 0;
		if (squeeze)
			hold_off = 1'b1;
		while (items_sent < PHASE_ITEMS) begin
			q.delete();
			kind = $urandom_range(0, 9);
			if (kind == 7) begin
				n = $urandom_range(1, 6);
				repeat (n) q.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 8) begin
				case ($urandom_range(0, 3))
					0: ;
					1: q.push_back($urandom_range(0, 1) ? "-" : "+");
					2: begin
						q.push_back("0");
						q.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						q.push_back("0");
						repeat ($urandom_range(2, 4)) q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end else begin
				if ((mode || $urandom_range(0, 7) == 0) && $urandom_range(0, 2) == 0)
					q.push_back($urandom_range(0, 1) ? "-" : "+");
				radix = radix_t'($urandom_range(0, 3));
				case (radix)
					RX_HEX: begin
						base = 16; maxlen = 16;
						q.push_back("0"); q.push_back("x");
					end
					RX_OCT: begin
						base = 8; maxlen = 22;
						q.push_back("0"); q.push_back("o");
					end
					RX_BIN: begin
						base = 2; maxlen = 64;
						q.push_back("0"); q.push_back("b");
					end
					default: begin
						base = 10; maxlen = 20;
					end
				endcase
				first = q.size();
				if (kind <= 2) begin
					case ($urandom_range(0, 5))
						0:       v = {$urandom, $urandom};
						1:       v = 64'h8000_0000_0000_0000;
						2:       v = 64'h7FFF_FFFF_FFFF_FFFF;
						3:       v = 64'h8000_0000_0000_0001;
						4:       v = 64'hFFFF_FFFF_FFFF_FFFF;
						default: v = 64'($urandom_range(0, 1000));
					endcase
					case (radix)
						RX_HEX:  s = $sformatf("%0h", v);
						RX_OCT:  s = $sformatf("%0o", v);
						RX_BIN:  s = $sformatf("%0b", v);
						default: s = $sformatf("%0d", v);
					endcase
					for (i = 0; i < s.len(); i++)
						q.push_back(s[i]);
				end else begin
					if ($urandom_range(0, 9) == 0)
						ndig = maxlen - 1 + $urandom_range(0, 2);
					else
						ndig = $urandom_range(1, 6);
					for (i = 0; i < ndig; i++) begin
						if (i == 0 && radix == RX_DEC && ndig > 1)
							digit = $urandom_range(1, 9);
						else
							digit = $urandom_range(0, base - 1);
						q.push_back(digit < 10 ? 8'(digit) + "0" : 8'(digit - 10) + "a");
					end
				end
				for (i = first; i < q.size(); i++)
					if (q[i] >= "a" && q[i] <= "z" && $urandom_range(0, 1))
						q[i] = q[i] ^ 8'h20;
				if (kind == 9)
					q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
			end
			send_bytes(q, $urandom_range(0, 7) == 0, 1'b1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(1'b1);
		send_text("", 1'b0);
		send_text("+", 1'b0);
		send_text("-", 1'b0);
		send_text("-0", 1'b0);
		send_text("0", 1'b0);
		send_text("0x", 1'b0);
		send_text("0q", 1'b0);
		send_text("0q1", 1'b0);
		send_text("0X1", 1'b0);
		send_text("0x7fffffffffffffff", 1'b0);
		send_text("0x8000000000000000", 1'b0);
		send_text("-0x8000000000000000", 1'b0);
		send_text("-0x8000000000000001", 1'b0);
		send_text("0b1011", 1'b0);
		send_text("0o777", 1'b0);
		send_text("+Zz", 1'b0);
		send_text("1#2", 1'b0);
		send_text("0x10000000000000000", 1'b0);
		send_text("0xfG", 1'b0);
		send_text("12", 1'b1);
		send_item("1", 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b0);
		send_item("2", 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);

		set_mode(1'b0);
		send_text("+1", 1'b0);
		send_text("-1", 1'b0);
		send_text("18446744073709551615", 1'b0);
		send_text("18446744073709551616", 1'b0);
		send_text("0xffffffffffffffff", 1'b0);

		run_random_phase(1'b1, 1'b0);
		run_random_phase(1'b0, 1'b1);
		run_random_phase(1'b1, 1'b0);
		run_random_phase(1'b0, 1'b0);
		run_random_phase(1'b1, 1'b0);

		wait_drained();
		if (sb.mismatches == 0)
			$display("prefixed_integer_literal_parser_top test passed");
		else
			$display("prefixed_integer_literal_parser_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/plip_pkg.sv
rtl/plip_decode.sv
rtl/plip_core.sv
rtl/plip_finish.sv
rtl/prefixed_integer_literal_parser_top.sv
bench/prefixed_integer_literal_parser_top_test.sv
